// File: rtl/core/svm_pkg.sv
// shared types, constants and helpers of the sample voice mixer
`default_nettype none

package svm_pkg;

   localparam int SAMPLE_WORDS_DEF = 65536;
   localparam int MAX_VOICES_DEF   = 16;
   localparam int ADDR_MAX_W       = 20;

   localparam logic [15:0] MIX_START     = 16'h8000;
   localparam logic [15:0] MIX_CEIL      = 16'hFFFF;
   localparam logic [7:0]  FRAME_HI_IDLE = 8'h80;
   localparam logic [7:0]  FRAME_LO_IDLE = 8'hC0;
   localparam logic [1:0]  FRAME_HI_MARK = 2'b10;
   localparam logic [1:0]  FRAME_LO_MARK = 2'b11;

   typedef enum logic [1:0] {
      CMD_LOAD  = 2'd0,
      CMD_START = 2'd1,
      CMD_STOP  = 2'd2,
      CMD_TICK  = 2'd3
   } cmd_type;

   typedef struct packed {
      logic init;
      logic add;
   } mix_ctl_type;

   // reduce a 16-bit address modulo the memory size, at least 1024 words
   function automatic logic [ADDR_MAX_W-1:0] wrap_addr(input logic [15:0] a,
                                                      input logic [25:0] words);
      logic [25:0] x;
      x = {10'b0, a};
      for (int k = 5; k >= 0; k--) begin
         if (x >= (words << k)) begin
            x = x - (words << k);
         end
      end
      return x[ADDR_MAX_W-1:0];
   endfunction

endpackage

`default_nettype wire

// File: rtl/core/svm_if.sv
// request and response channel interfaces of the sample voice mixer
`default_nettype none

interface svm_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         command;
   logic [15:0]        address;
   logic signed [15:0] sample_value;
   logic [16:0]        length;
   logic [15:0]        voice_id;

   modport source (output valid, command, address, sample_value, length, voice_id,
                   input ready);
   modport sink (input valid, command, address, sample_value, length, voice_id,
                 output ready);
endinterface

interface svm_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] mixed_word;
   logic [7:0]  frame_high;
   logic [7:0]  frame_low;
   logic [15:0] id_result;
   logic        accepted;

   modport source (output valid, mixed_word, frame_high, frame_low, id_result, accepted,
                   input ready);
   modport sink (input valid, mixed_word, frame_high, frame_low, id_result, accepted,
                 output ready);
endinterface

`default_nettype wire

// File: rtl/core/svm_sample_mem.sv
// sample memory: one write port, one registered read port
`default_nettype none

module svm_sample_mem
   import svm_pkg::*;
#(
   parameter int SAMPLE_WORDS = SAMPLE_WORDS_DEF,
   parameter int AW           = $clog2(SAMPLE_WORDS)
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [AW-1:0]     wr_addr,
   input  wire logic [15:0]       wr_data,
   input  wire logic              rd_en,
   input  wire logic [AW-1:0]     rd_addr,
   output logic signed [15:0]     rd_data_ff
);

   logic [15:0] mem [SAMPLE_WORDS];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

// File: rtl/core/svm_voice_list.sv
// voice list entries: one read index, one write index per cycle
`default_nettype none

module svm_voice_list
   import svm_pkg::*;
#(
   parameter int MAX_VOICES = MAX_VOICES_DEF,
   parameter int AW         = 16,
   parameter int IW         = (MAX_VOICES > 1) ? $clog2(MAX_VOICES) : 1
) (
   input  wire logic            clock,
   input  wire logic [IW-1:0]   rd_idx,
   output logic [AW-1:0]        rd_addr,
   output logic [16:0]          rd_span,
   output logic [16:0]          rd_pos,
   output logic [15:0]          rd_tag,
   input  wire logic            wr_en,
   input  wire logic [IW-1:0]   wr_idx,
   input  wire logic [AW-1:0]   wr_addr,
   input  wire logic [16:0]     wr_span,
   input  wire logic [16:0]     wr_pos,
   input  wire logic [15:0]     wr_tag
);

   // addr holds the current read address of the voice, already wrapped
   logic [AW-1:0] addr_ff [MAX_VOICES];
   logic [16:0]   span_ff [MAX_VOICES];
   logic [16:0]   pos_ff  [MAX_VOICES];
   logic [15:0]   tag_ff  [MAX_VOICES];

   assign rd_addr = addr_ff[rd_idx];
   assign rd_span = span_ff[rd_idx];
   assign rd_pos  = pos_ff[rd_idx];
   assign rd_tag  = tag_ff[rd_idx];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         addr_ff[wr_idx] <= wr_addr;
         span_ff[wr_idx] <= wr_span;
         pos_ff[wr_idx]  <= wr_pos;
         tag_ff[wr_idx]  <= wr_tag;
      end
   end

endmodule

`default_nettype wire

// File: rtl/core/svm_mix_acc.sv
// mix accumulator: saturating add of one voice sample per cycle while add is set, output framing
`default_nettype none

module svm_mix_acc
   import svm_pkg::*;
(
   input  wire logic               clock,
   input  wire mix_ctl_type        ctl,
   input  wire logic signed [15:0] sample,
   output logic [15:0]             mixed_word,
   output logic [7:0]              frame_high,
   output logic [7:0]              frame_low
);

   logic [15:0]        sum_ff;
   logic [15:0]        sum_in;
   logic signed [17:0] total;

   always_comb begin
      total  = $signed({2'b00, sum_ff}) + 18'(sample);
      sum_in = sum_ff;
      if (ctl.init) begin
         sum_in = MIX_START;
      end else if (ctl.add) begin
         if (total[17]) begin
            sum_in = '0;
         end else if (total[16]) begin
            sum_in = MIX_CEIL;
         end else begin
            sum_in = total[15:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      sum_ff <= sum_in;
   end

   // 12-bit value split into two six-bit halves
   assign mixed_word = {sum_ff[15:4], 4'b0000};
   assign frame_high = {FRAME_HI_MARK, sum_ff[15:10]};
   assign frame_low  = {FRAME_LO_MARK, sum_ff[9:4]};

endmodule

`default_nettype wire

// File: rtl/core/sample_voice_mixer_top.sv
// top level of the sample voice mixer: command sequencer and result register
// response valid after the request transfer: load writes the sample memory, start and stop search
// the list, stop then closes the gap, tick fetches and accumulates one voice per cycle
// one request at a time, ready again the cycle after its response is loaded
// a response not yet taken holds the next command in its last cycle
// reset clears the sequencer and empties the voice list; memories are not cleared
`default_nettype none

module sample_voice_mixer_top
   import svm_pkg::*;
#(
   parameter int SAMPLE_WORDS = SAMPLE_WORDS_DEF,
   parameter int MAX_VOICES   = MAX_VOICES_DEF
) (
   input  wire logic clock,
   input  wire logic reset,
   svm_req_if.sink   req_chan,
   svm_rsp_if.source rsp_chan
);

   localparam int AW = $clog2(SAMPLE_WORDS);
   localparam int IW = (MAX_VOICES > 1) ? $clog2(MAX_VOICES) : 1;
   localparam int CW = $clog2(MAX_VOICES + 1);
   localparam logic [CW-1:0] VOICES_MAX = CW'(MAX_VOICES);
   localparam logic [AW-1:0] ADDR_LAST  = AW'(SAMPLE_WORDS - 1);

   typedef enum logic [2:0] {
      S_IDLE,
      S_LOAD,
      S_FIND,
      S_SHIFT,
      S_TICK,
      S_DONE
   } state_type;

   state_type   state_ff, state_in;
   cmd_type     cmd_ff, cmd_in;
   logic [15:0] addr_ff, addr_in;
   logic [15:0] val_ff, val_in;
   logic [16:0] len_ff, len_in;
   logic [15:0] id_ff, id_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic [CW-1:0] keep_ff, keep_in;
   logic [CW-1:0] idx_next;

   logic          p_valid_ff, p_valid_in;
   logic          p_act_ff, p_act_in;
   logic [AW-1:0] p_addr_ff, p_addr_in;
   logic [16:0]   p_span_ff, p_span_in;
   logic [16:0]   p_pos_ff, p_pos_in;
   logic [15:0]   p_tag_ff, p_tag_in;

   logic        res_tick_ff, res_tick_in;
   logic        res_acc_ff, res_acc_in;
   logic [15:0] res_idr_ff, res_idr_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [15:0] rsp_mixed_ff, rsp_mixed_in;
   logic [7:0]  rsp_hi_ff, rsp_hi_in;
   logic [7:0]  rsp_lo_ff, rsp_lo_in;
   logic [15:0] rsp_idr_ff, rsp_idr_in;
   logic        rsp_acc_ff, rsp_acc_in;

   logic [IW-1:0] vl_rd_idx;
   logic [AW-1:0] vl_rd_addr;
   logic [16:0]   vl_rd_span;
   logic [16:0]   vl_rd_pos;
   logic [15:0]   vl_rd_tag;
   logic          vl_wr_en;
   logic [IW-1:0] vl_wr_idx;
   logic [AW-1:0] vl_wr_addr;
   logic [16:0]   vl_wr_span;
   logic [16:0]   vl_wr_pos;
   logic [15:0]   vl_wr_tag;

   logic               mem_wr_en;
   logic               mem_rd_en;
   logic [AW-1:0]      mem_wr_addr;
   logic signed [15:0] mem_rd_data;

   mix_ctl_type mix_ctl;
   logic [15:0] mix_word;
   logic [7:0]  mix_hi;
   logic [7:0]  mix_lo;

   logic [AW-1:0] cmd_addr;
   logic [16:0]   p_pos_next;
   logic [AW-1:0] p_addr_next;

   svm_voice_list #(
      .MAX_VOICES (MAX_VOICES),
      .AW         (AW),
      .IW         (IW)
   ) u_voice_list (
      .clock   (clock),
      .rd_idx  (vl_rd_idx),
      .rd_addr (vl_rd_addr),
      .rd_span (vl_rd_span),
      .rd_pos  (vl_rd_pos),
      .rd_tag  (vl_rd_tag),
      .wr_en   (vl_wr_en),
      .wr_idx  (vl_wr_idx),
      .wr_addr (vl_wr_addr),
      .wr_span (vl_wr_span),
      .wr_pos  (vl_wr_pos),
      .wr_tag  (vl_wr_tag)
   );

   svm_sample_mem #(
      .SAMPLE_WORDS (SAMPLE_WORDS),
      .AW           (AW)
   ) u_sample_mem (
      .clock      (clock),
      .wr_en      (mem_wr_en),
      .wr_addr    (mem_wr_addr),
      .wr_data    (val_ff),
      .rd_en      (mem_rd_en),
      .rd_addr    (vl_rd_addr),
      .rd_data_ff (mem_rd_data)
   );

   svm_mix_acc u_mix_acc (
      .clock      (clock),
      .ctl        (mix_ctl),
      .sample     (mem_rd_data),
      .mixed_word (mix_word),
      .frame_high (mix_hi),
      .frame_low  (mix_lo)
   );

   assign req_chan.ready        = (state_ff == S_IDLE);
   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.mixed_word   = rsp_mixed_ff;
   assign rsp_chan.frame_high   = rsp_hi_ff;
   assign rsp_chan.frame_low    = rsp_lo_ff;
   assign rsp_chan.id_result    = rsp_idr_ff;
   assign rsp_chan.accepted     = rsp_acc_ff;

   assign cmd_addr    = AW'(wrap_addr(addr_ff, 26'(SAMPLE_WORDS)));
   assign mem_wr_addr = cmd_addr;
   assign idx_next    = idx_ff + CW'(1);
   assign p_pos_next  = p_pos_ff + 17'd1;
   assign p_addr_next = (p_addr_ff == ADDR_LAST) ? '0 : p_addr_ff + AW'(1);

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      addr_in      = addr_ff;
      val_in       = val_ff;
      len_in       = len_ff;
      id_in        = id_ff;
      count_in     = count_ff;
      idx_in       = idx_ff;
      keep_in      = keep_ff;
      p_valid_in   = p_valid_ff;
      p_act_in     = p_act_ff;
      p_addr_in    = p_addr_ff;
      p_span_in    = p_span_ff;
      p_pos_in     = p_pos_ff;
      p_tag_in     = p_tag_ff;
      res_tick_in  = res_tick_ff;
      res_acc_in   = res_acc_ff;
      res_idr_in   = res_idr_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_mixed_in = rsp_mixed_ff;
      rsp_hi_in    = rsp_hi_ff;
      rsp_lo_in    = rsp_lo_ff;
      rsp_idr_in   = rsp_idr_ff;
      rsp_acc_in   = rsp_acc_ff;

      vl_rd_idx  = idx_ff[IW-1:0];
      vl_wr_en   = 1'b0;
      vl_wr_idx  = idx_ff[IW-1:0];
      vl_wr_addr = vl_rd_addr;
      vl_wr_span = vl_rd_span;
      vl_wr_pos  = vl_rd_pos;
      vl_wr_tag  = vl_rd_tag;
      mem_wr_en  = 1'b0;
      mem_rd_en  = 1'b0;
      mix_ctl    = '0;

      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_chan.valid) begin
               cmd_in     = cmd_type'(req_chan.command);
               addr_in    = req_chan.address;
               val_in     = req_chan.sample_value;
               len_in     = req_chan.length;
               id_in      = req_chan.voice_id;
               idx_in     = '0;
               keep_in    = '0;
               p_valid_in = 1'b0;
               case (cmd_type'(req_chan.command))
                  CMD_LOAD: state_in = S_LOAD;
                  CMD_START, CMD_STOP: state_in = S_FIND;
                  CMD_TICK: begin
                     mix_ctl.init = 1'b1;
                     state_in     = S_TICK;
                  end
                  default: state_in = S_IDLE;
               endcase
            end
         end
         S_LOAD: begin
            mem_wr_en   = 1'b1;
            res_tick_in = 1'b0;
            res_acc_in  = 1'b1;
            res_idr_in  = '0;
            state_in    = S_DONE;
         end
         S_FIND: begin
            res_tick_in = 1'b0;
            if (idx_ff == count_ff) begin
               // id not in the list
               if (cmd_ff == CMD_START && id_ff != '0 && count_ff < VOICES_MAX) begin
                  vl_wr_en   = 1'b1;
                  vl_wr_idx  = count_ff[IW-1:0];
                  vl_wr_addr = cmd_addr;
                  vl_wr_span = len_ff;
                  vl_wr_pos  = '0;
                  vl_wr_tag  = id_ff;
                  count_in   = count_ff + CW'(1);
                  res_acc_in = 1'b1;
                  res_idr_in = id_ff;
               end else begin
                  res_acc_in = 1'b0;
                  res_idr_in = '0;
               end
               state_in = S_DONE;
            end else if (vl_rd_tag == id_ff) begin
               if (cmd_ff == CMD_START) begin
                  res_acc_in = 1'b0;
                  res_idr_in = '0;
                  state_in   = S_DONE;
               end else begin
                  state_in = S_SHIFT;
               end
            end else begin
               idx_in = idx_next;
            end
         end
         S_SHIFT: begin
            // close the gap one entry per cycle
            vl_rd_idx = idx_next[IW-1:0];
            if (idx_next < count_ff) begin
               vl_wr_en = 1'b1;
               idx_in   = idx_next;
            end else begin
               count_in   = count_ff - CW'(1);
               res_acc_in = 1'b1;
               res_idr_in = id_ff;
               state_in   = S_DONE;
            end
         end
         S_TICK: begin
            // issue side: fetch entry and its sample
            if (idx_ff != count_ff) begin
               mem_rd_en  = (vl_rd_pos < vl_rd_span);
               p_valid_in = 1'b1;
               p_act_in   = (vl_rd_pos < vl_rd_span);
               p_addr_in  = vl_rd_addr;
               p_span_in  = vl_rd_span;
               p_pos_in   = vl_rd_pos;
               p_tag_in   = vl_rd_tag;
               idx_in     = idx_next;
            end else begin
               p_valid_in = 1'b0;
            end
            // retire side: accumulate, advance, keep survivors in order
            if (p_valid_ff && p_act_ff) begin
               mix_ctl.add = 1'b1;
               if (p_pos_next < p_span_ff) begin
                  vl_wr_en   = 1'b1;
                  vl_wr_idx  = keep_ff[IW-1:0];
                  vl_wr_addr = p_addr_next;
                  vl_wr_span = p_span_ff;
                  vl_wr_pos  = p_pos_next;
                  vl_wr_tag  = p_tag_ff;
                  keep_in    = keep_ff + CW'(1);
               end
            end
            if (idx_ff == count_ff && !p_valid_ff) begin
               count_in    = keep_ff;
               res_tick_in = 1'b1;
               res_acc_in  = 1'b1;
               res_idr_in  = '0;
               state_in    = S_DONE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in = 1'b1;
               rsp_mixed_in = res_tick_ff ? mix_word : '0;
               rsp_hi_in    = res_tick_ff ? mix_hi : FRAME_HI_IDLE;
               rsp_lo_in    = res_tick_ff ? mix_lo : FRAME_LO_IDLE;
               rsp_idr_in   = res_idr_ff;
               rsp_acc_in   = res_acc_ff;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         idx_ff       <= '0;
         keep_ff      <= '0;
         p_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         idx_ff       <= idx_in;
         keep_ff      <= keep_in;
         p_valid_ff   <= p_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff       <= cmd_in;
      addr_ff      <= addr_in;
      val_ff       <= val_in;
      len_ff       <= len_in;
      id_ff        <= id_in;
      p_act_ff     <= p_act_in;
      p_addr_ff    <= p_addr_in;
      p_span_ff    <= p_span_in;
      p_pos_ff     <= p_pos_in;
      p_tag_ff     <= p_tag_in;
      res_tick_ff  <= res_tick_in;
      res_acc_ff   <= res_acc_in;
      res_idr_ff   <= res_idr_in;
      rsp_mixed_ff <= rsp_mixed_in;
      rsp_hi_ff    <= rsp_hi_in;
      rsp_lo_ff    <= rsp_lo_in;
      rsp_idr_ff   <= rsp_idr_in;
      rsp_acc_ff   <= rsp_acc_in;
   end

`ifndef SYNTH
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= VOICES_MAX)
      else $error("voice count beyond list size");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_DONE))
      else $error("response raised outside the done state");

   a_tick_drained: assert property (@(posedge clock) disable iff (reset)
      req_chan.ready |-> !p_valid_ff)
      else $error("voice pipeline busy while taking a request");

   a_keep_behind: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_TICK |-> keep_ff <= idx_ff)
      else $error("compaction index ahead of fetch index");
`endif

endmodule

`default_nettype wire

// File: bench/sample_voice_mixer_top_tb.sv
// self-checking testbench of the sample voice mixer top level
`timescale 1ns / 100ps

module sample_voice_mixer_top_tb;
   import svm_pkg::*;

   localparam int TONE_SLOTS  = MAX_VOICES_DEF;
   localparam int STALL_LIMIT = 4000;
   localparam int TAIL_CYCLES = 60;

   typedef struct packed {
      logic [15:0] mixed;
      logic [7:0]  hi;
      logic [7:0]  lo;
      logic [15:0] id;
      logic        acc;
   } mix_result_type;

   logic clock;
   logic reset;

   svm_req_if req_if();
   svm_rsp_if rsp_if();

   sample_voice_mixer_top u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   // mirror of the mixer state
   logic [15:0] sample_mem    [SAMPLE_WORDS_DEF];
   bit          sample_loaded [SAMPLE_WORDS_DEF];
   logic [15:0] tone_base [TONE_SLOTS];
   logic [16:0] tone_len  [TONE_SLOTS];
   logic [16:0] tone_pos  [TONE_SLOTS];
   logic [15:0] tone_id   [TONE_SLOTS];
   int          tone_count;

   mix_result_type expected_results[$];
   int             mismatch_count;
   int             req_gap_max;
   int             rsp_gap_max;
   int             hold_off_cycles;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic int find_tone(input logic [15:0] id);
      for (int i = 0; i < tone_count; i++) begin
         if (tone_id[i] == id) begin
            return i;
         end
      end
      return -1;
   endfunction

   function automatic void copy_tone(input int dst, input int src);
      tone_base[dst] = tone_base[src];
      tone_len[dst]  = tone_len[src];
      tone_pos[dst]  = tone_pos[src];
      tone_id[dst]   = tone_id[src];
   endfunction

   task automatic predict_result(input cmd_type op, input logic [15:0] addr,
                                 input logic [15:0] value, input logic [16:0] len,
                                 input logic [15:0] id);
      mix_result_type r;
      int             hit;
      int             level;
      int             keep;
      logic [15:0]    slot_addr;
      logic [11:0]    code;
      r       = '0;
      r.hi    = FRAME_HI_IDLE;
      r.lo    = FRAME_LO_IDLE;
      case (op)
         CMD_LOAD: begin
            sample_mem[addr]    = value;
            sample_loaded[addr] = 1'b1;
            r.acc               = 1'b1;
         end
         CMD_START: begin
            if (id != 16'h0000 && find_tone(id) < 0 && tone_count < TONE_SLOTS) begin
               tone_base[tone_count] = addr;
               tone_len[tone_count]  = len;
               tone_pos[tone_count]  = '0;
               tone_id[tone_count]   = id;
               tone_count++;
               r.id  = id;
               r.acc = 1'b1;
            end
         end
         CMD_STOP: begin
            hit = find_tone(id);
            if (hit >= 0) begin
               for (int i = hit; i + 1 < tone_count; i++) begin
                  copy_tone(i, i + 1);
               end
               tone_count--;
               r.id  = id;
               r.acc = 1'b1;
            end
         end
         default: begin
            // saturate after every voice, in list order
            level = int'(MIX_START);
            for (int i = 0; i < tone_count; i++) begin
               if (tone_pos[i] < tone_len[i]) begin
                  slot_addr = tone_base[i] + tone_pos[i][15:0];
                  level += int'($signed(sample_mem[slot_addr]));
                  if (level > int'(MIX_CEIL)) begin
                     level = int'(MIX_CEIL);
                  end else if (level < 0) begin
                     level = 0;
                  end
                  tone_pos[i]++;
               end
            end
            keep = 0;
            for (int i = 0; i < tone_count; i++) begin
               if (tone_pos[i] < tone_len[i]) begin
                  copy_tone(keep, i);
                  keep++;
               end
            end
            tone_count = keep;
            r.mixed    = level[15:0] & 16'hFFF0;
            code       = r.mixed[15:4];
            r.hi       = {FRAME_HI_MARK, code[11:6]};
            r.lo       = {FRAME_LO_MARK, code[5:0]};
            r.acc      = 1'b1;
         end
      endcase
      expected_results = {expected_results, r};
   endtask

   // valid stays high after a transfer; the next call either changes the payload or drops it
   task automatic send_command(input cmd_type op, input logic [15:0] addr,
                               input logic [15:0] value, input logic [16:0] len,
                               input logic [15:0] id);
      int gap;
      gap = $urandom_range(0, req_gap_max);
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid        <= 1'b1;
      req_if.command      <= op;
      req_if.address      <= addr;
      req_if.sample_value <= value;
      req_if.length       <= len;
      req_if.voice_id     <= id;
      do @(posedge clock); while (req_if.ready !== 1'b1);
      predict_result(op, addr, value, len, id);
   endtask

   task automatic wait_for_drain();
      req_if.valid <= 1'b0;
      do @(posedge clock); while (expected_results.size() != 0);
   endtask

   function automatic logic [15:0] pick_sample();
      case ($urandom_range(0, 5))
         0: return 16'h7FFF;
         1: return 16'h8000;
         2: return 16'($urandom_range(0, 1023)) - 16'd512;
         default: return 16'($urandom);
      endcase
   endfunction

   // voices mostly play from a few windows so loaded words get reused
   function automatic logic [15:0] pick_base();
      logic [15:0] window;
      case ($urandom_range(0, 9))
         0, 1: window = 16'hFFF0;
         2, 3: window = 16'h0000;
         4, 5: window = 16'h8000;
         6, 7, 8: window = 16'h3C40;
         default: return 16'($urandom);
      endcase
      return window + 16'($urandom_range(0, 31));
   endfunction

   function automatic logic [16:0] pick_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 75) begin
         return 17'($urandom_range(0, 8));
      end else if (r < 95) begin
         return 17'($urandom_range(9, 48));
      end else if (r < 97) begin
         return 17'h10000;
      end
      return 17'($urandom_range(0, 65536));
   endfunction

   function automatic logic [15:0] pick_start_id();
      int r;
      r = $urandom_range(0, 19);
      if (r == 0) begin
         return 16'h0000;
      end else if (r < 14) begin
         return 16'($urandom_range(1, 24));
      end else if (r == 14) begin
         return 16'hFFFF;
      end
      return 16'($urandom);
   endfunction

   function automatic logic [15:0] pick_stop_id();
      int r;
      r = $urandom_range(0, 9);
      if (tone_count > 0 && r < 7) begin
         return tone_id[$urandom_range(0, tone_count - 1)];
      end else if (r == 7) begin
         return 16'h0000;
      end
      return 16'($urandom_range(1, 40));
   endfunction

   // load any word a live voice is about to read, then tick
   task automatic play_tick();
      logic [15:0] slot_addr;
      for (int i = 0; i < tone_count; i++) begin
         slot_addr = tone_base[i] + tone_pos[i][15:0];
         if (tone_pos[i] < tone_len[i] && !sample_loaded[slot_addr]) begin
            send_command(CMD_LOAD, slot_addr, pick_sample(), 17'($urandom), 16'($urandom));
         end
      end
      send_command(CMD_TICK, 16'($urandom), 16'($urandom), 17'($urandom), 16'($urandom));
   endtask

   task automatic random_command(input int load_pct, input int start_pct, input int stop_pct);
      int          r;
      logic [15:0] addr;
      r = $urandom_range(0, 99);
      if (r < load_pct) begin
         addr = ($urandom_range(0, 1) == 0) ? 16'($urandom)
                                            : pick_base() + 16'($urandom_range(0, 40));
         send_command(CMD_LOAD, addr, pick_sample(), 17'($urandom), 16'($urandom));
      end else if (r < load_pct + start_pct) begin
         send_command(CMD_START, pick_base(), 16'($urandom), pick_length(), pick_start_id());
      end else if (r < load_pct + start_pct + stop_pct) begin
         send_command(CMD_STOP, 16'($urandom), 16'($urandom), 17'($urandom), pick_stop_id());
      end else begin
         play_tick();
      end
   endtask

   task automatic test_directed_cases();
      req_gap_max = 8;
      rsp_gap_max = 8;
      play_tick();
      send_command(CMD_LOAD, 16'hFFFF, 16'h7FFF, 17'h00000, 16'h0000);
      send_command(CMD_LOAD, 16'h0000, 16'h7FFF, 17'h1FFFF, 16'hFFFF);
      send_command(CMD_LOAD, 16'h0001, 16'h8000, 17'h00000, 16'h0000);
      // voice that wraps past the top of memory
      send_command(CMD_START, 16'hFFFF, 16'h0000, 17'd3, 16'hFFFF);
      send_command(CMD_START, 16'h0000, 16'h0000, 17'd5, 16'h0000);
      send_command(CMD_START, 16'h0000, 16'h0000, 17'd5, 16'hFFFF);
      send_command(CMD_START, 16'h0000, 16'h0000, 17'd0, 16'h0001);
      send_command(CMD_START, 16'hFFFF, 16'h0000, 17'h10000, 16'h0002);
      // clamp high twice, then low
      play_tick();
      play_tick();
      play_tick();
      send_command(CMD_STOP, 16'h0000, 16'h0000, 17'd0, 16'h0002);
      send_command(CMD_STOP, 16'h0000, 16'h0000, 17'd0, 16'h0002);
      send_command(CMD_STOP, 16'hFFFF, 16'hFFFF, 17'h1FFFF, 16'h0000);
      send_command(CMD_LOAD, 16'h5555, 16'h0001, 17'h0AAAA, 16'h5555);
      send_command(CMD_LOAD, 16'hAAAA, 16'hFFFE, 17'h15555, 16'hAAAA);
      play_tick();
   endtask

   task automatic test_random_playback();
      req_gap_max = 8;
      rsp_gap_max = 8;
      repeat (110) random_command(15, 25, 15);
   endtask

   task automatic test_back_to_back();
      req_gap_max = 0;
      rsp_gap_max = 0;
      repeat (70) random_command(15, 25, 15);
   endtask

   task automatic test_crowded_voice_list();
      req_gap_max = 8;
      rsp_gap_max = 0;
      repeat (40) random_command(10, 60, 10);
   endtask

   task automatic test_output_backpressure();
      req_gap_max     = 0;
      rsp_gap_max     = 8;
      hold_off_cycles = 300;
      repeat (30) random_command(15, 25, 15);
   endtask

   task automatic test_pause_and_resume();
      req_gap_max = 8;
      rsp_gap_max = 8;
      repeat (3) begin
         repeat (10) random_command(15, 25, 15);
         wait_for_drain();
      end
   endtask

   initial begin
      mismatch_count      = 0;
      tone_count          = 0;
      req_gap_max         = 0;
      rsp_gap_max         = 0;
      hold_off_cycles     = 0;
      reset               <= 1'b1;
      req_if.valid        <= 1'b0;
      req_if.command      <= CMD_LOAD;
      req_if.address      <= '0;
      req_if.sample_value <= '0;
      req_if.length       <= '0;
      req_if.voice_id     <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_cases();
      test_random_playback();
      test_back_to_back();
      test_crowded_voice_list();
      test_output_backpressure();
      test_pause_and_resume();
      wait_for_drain();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   task automatic compare_field(input string name, input logic [15:0] want,
                                input logic [15:0] got);
      if (got !== want) begin
         $display("%0t ns: %s mismatch, expected %h actual %h", $time, name, want, got);
         mismatch_count++;
      end
   endtask

   initial begin : result_checker
      int             stall;
      mix_result_type want;
      rsp_if.ready <= 1'b0;
      do @(posedge clock); while (reset !== 1'b0);
      forever begin
         stall           = (hold_off_cycles > 0) ? hold_off_cycles
                                                 : $urandom_range(0, rsp_gap_max);
         hold_off_cycles = 0;
         if (stall > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_if.ready <= 1'b1;
         do @(posedge clock); while (rsp_if.valid !== 1'b1);
         if (expected_results.size() == 0) begin
            $display("%0t ns: result transfer with nothing expected", $time);
            mismatch_count++;
         end else begin
            want = expected_results.pop_front();
            compare_field("mixed_word", want.mixed, rsp_if.mixed_word);
            compare_field("frame_high", 16'(want.hi), 16'(rsp_if.frame_high));
            compare_field("frame_low", 16'(want.lo), 16'(rsp_if.frame_low));
            compare_field("id_result", want.id, rsp_if.id_result);
            compare_field("accepted", 16'(want.acc), 16'(rsp_if.accepted));
         end
      end
   end

   initial begin : stall_watchdog
      int quiet_cycles;
      quiet_cycles = 0;
      forever begin
         @(posedge clock);
         if ((req_if.valid === 1'b1 && req_if.ready === 1'b1) ||
             (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t ns: no transfer for %0d cycles", $time, quiet_cycles);
            $display("TEST FAILED");
            $finish;
         end
      end
   end

endmodule
